// ===== src/tsnt_pkg.sv =====
`default_nettype none

package tsnt_pkg;

  // fixed field widths of the ports
  localparam int KEY_FIELD_W = 48;
  localparam int HANDLE_W    = 16;
  localparam int STATUS_W    = 3;
  localparam int WIDE_W      = 64;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STS_REPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] STS_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd4;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_GAP,
    ST_DONE
  } state_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
    logic repl_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/tsnt_cell.sv =====
`default_nettype none

module tsnt_cell import tsnt_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  wire logic                 clk,
  input  wire cell_ctl_t            ctl,
  input  wire logic                 valid,
  input  wire logic [TIME_BITS-1:0] key_cmp,
  input  wire logic [TIME_BITS-1:0] key_new,
  input  wire logic [HANDLE_W-1:0]  handle_new,
  input  wire logic [TIME_BITS-1:0] left_time,
  input  wire logic [HANDLE_W-1:0]  left_handle,
  input  wire logic                 left_ins,
  output logic      [TIME_BITS-1:0] time_o,
  output logic      [HANDLE_W-1:0]  handle_o,
  output logic                      ins_o,
  output logic                      eq_o
);

  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [HANDLE_W-1:0]  handle_r, handle_nxt;
  logic                 ins_r;
  logic                 eq_r;

  // shift from the left neighbour, take the new word at the boundary, or replace
  always_comb begin
    time_nxt   = time_r;
    handle_nxt = handle_r;
    if (ctl.shift_en && ins_r) begin
      if (left_ins) begin
        time_nxt   = left_time;
        handle_nxt = left_handle;
      end else begin
        time_nxt   = key_new;
        handle_nxt = handle_new;
      end
    end else if (ctl.repl_en && eq_r) begin
      handle_nxt = handle_new;
    end
  end

  // stored record
  always_ff @(posedge clk) begin
    time_r   <= time_nxt;
    handle_r <= handle_nxt;
  end

  // compare flags: an empty cell counts as later than any key
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      ins_r <= !valid || (time_r > key_cmp);
      eq_r  <= valid && (time_r == key_cmp);
    end
  end

  assign time_o   = time_r;
  assign handle_o = handle_r;
  assign ins_o    = ins_r;
  assign eq_o     = eq_r;

endmodule

`default_nettype wire

// ===== src/time_sorted_nearest_table_core.sv =====
// sequence: a word accepted while idle is compared in every cell; an insert then shifts or replaces
//   and gives its result, a search on an empty table gives EMPTY, and any other search picks the
//   two neighbours, then forms their gaps, then gives its result; busy holds off new words until idle
// reset: synchronous active-low rst_n empties the table (fill count to zero) and idles
// here the receiver cannot stall: out_valid is a one-cycle strobe
`default_nettype none

module time_sorted_nearest_table_core import tsnt_pkg::*; #(
  parameter int TABLE_DEPTH = 32,
  parameter int TIME_BITS   = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   in_opcode,
  input  wire logic [KEY_FIELD_W-1:0] in_key_time,
  input  wire logic [HANDLE_W-1:0]    in_record_handle,
  output logic                        out_valid,
  output logic      [STATUS_W-1:0]    out_status,
  output logic      [HANDLE_W-1:0]    out_found_handle,
  output logic      [KEY_FIELD_W-1:0] out_found_time,
  output logic      [KEY_FIELD_W-1:0] out_time_distance
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;
  cell_ctl_t ctl;

  logic [CW-1:0]        fill_r;
  logic                 op_r;
  logic [TIME_BITS-1:0] key_r;
  logic [HANDLE_W-1:0]  handle_r;

  logic [WIDE_W-1:0]    key_ext;
  logic [TIME_BITS-1:0] key_in;

  logic [TIME_BITS-1:0] cell_time   [TABLE_DEPTH];
  logic [HANDLE_W-1:0]  cell_handle [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_ins, cell_eq, cell_valid, pred_hot, succ_hot;

  logic accept, any_eq, full, empty;
  logic sel_load, gap_load, res_ins, res_empty, res_found;

  logic [TIME_BITS-1:0] pred_time_sel, succ_time_sel;
  logic [HANDLE_W-1:0]  pred_handle_sel, succ_handle_sel;
  logic [TIME_BITS-1:0] pred_time_r, succ_time_r, gap_p_r, gap_s_r;
  logic [HANDLE_W-1:0]  pred_handle_r, succ_handle_r;
  logic                 has_pred_r, has_succ_r;
  logic                 pick_pred;
  logic [WIDE_W-1:0]    time_ext, dist_ext;

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    status_r;
  logic [HANDLE_W-1:0]    found_handle_r;
  logic [KEY_FIELD_W-1:0] found_time_r, distance_r;

  // key masked to the table's time width
  assign key_ext = WIDE_W'(in_key_time);
  assign key_in  = key_ext[TIME_BITS-1:0];

  assign accept = start && !busy;
  assign any_eq = |cell_eq;
  assign full   = (fill_r == CW'(TABLE_DEPTH));
  assign empty  = (fill_r == '0);

  // row of cells, each fed by its left neighbour; the first is fed zeros
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [TIME_BITS-1:0] l_time;
    logic [HANDLE_W-1:0]  l_handle;
    logic                 l_ins;
    if (i == 0) begin : g_first
      assign l_time   = '0;
      assign l_handle = '0;
      assign l_ins    = 1'b0;
    end else begin : g_rest
      assign l_time   = cell_time[i-1];
      assign l_handle = cell_handle[i-1];
      assign l_ins    = cell_ins[i-1];
    end
    assign cell_valid[i] = (CW'(i) < fill_r);

    tsnt_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (cell_valid[i]),
      .key_cmp     (key_in),
      .key_new     (key_r),
      .handle_new  (handle_r),
      .left_time   (l_time),
      .left_handle (l_handle),
      .left_ins    (l_ins),
      .time_o      (cell_time[i]),
      .handle_o    (cell_handle[i]),
      .ins_o       (cell_ins[i]),
      .eq_o        (cell_eq[i])
    );

    // last key not after the query, and first stored key after it
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign pred_hot[i] = !cell_ins[i];
    end else begin : g_mid
      assign pred_hot[i] = !cell_ins[i] && cell_ins[i+1];
    end
    if (i == 0) begin : g_s0
      assign succ_hot[i] = cell_ins[i] && cell_valid[i];
    end else begin : g_sn
      assign succ_hot[i] = cell_ins[i] && cell_valid[i] && !cell_ins[i-1];
    end
  end

  // one-hot pick of the two neighbours of the query
  always_comb begin
    pred_time_sel   = '0;
    succ_time_sel   = '0;
    pred_handle_sel = '0;
    succ_handle_sel = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pred_time_sel   = pred_time_sel   | (cell_time[i]   & {TIME_BITS{pred_hot[i]}});
      succ_time_sel   = succ_time_sel   | (cell_time[i]   & {TIME_BITS{succ_hot[i]}});
      pred_handle_sel = pred_handle_sel | (cell_handle[i] & {HANDLE_W{pred_hot[i]}});
      succ_handle_sel = succ_handle_sel | (cell_handle[i] & {HANDLE_W{succ_hot[i]}});
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = (op_r == OP_SEARCH && !empty) ? ST_GAP : ST_IDLE;
      ST_GAP:  state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy         = (state_r != ST_IDLE);
    ctl.cmp_en   = accept;
    ctl.shift_en = 1'b0;
    ctl.repl_en  = 1'b0;
    sel_load     = 1'b0;
    gap_load     = 1'b0;
    res_ins      = 1'b0;
    res_empty    = 1'b0;
    res_found    = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_EVAL: begin
        if (op_r == OP_INSERT) begin
          res_ins      = 1'b1;
          ctl.repl_en  = any_eq;
          ctl.shift_en = !any_eq && !full;
        end else begin
          res_empty = empty;
          sel_load  = !empty;
        end
      end
      ST_GAP:  gap_load  = 1'b1;
      ST_DONE: res_found = 1'b1;
      default: ;
    endcase
  end

  // state and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.shift_en) fill_r <= fill_r + CW'(1);
    end
  end

  // captured word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_opcode;
      key_r    <= key_in;
      handle_r <= in_record_handle;
    end
  end

  // neighbour and gap stages
  always_ff @(posedge clk) begin
    if (sel_load) begin
      pred_time_r   <= pred_time_sel;
      succ_time_r   <= succ_time_sel;
      pred_handle_r <= pred_handle_sel;
      succ_handle_r <= succ_handle_sel;
      has_pred_r    <= |pred_hot;
      has_succ_r    <= |succ_hot;
    end
    if (gap_load) begin
      gap_p_r <= key_r - pred_time_r;
      gap_s_r <= succ_time_r - key_r;
    end
  end

  // tie goes to the later key
  assign pick_pred = has_pred_r && (!has_succ_r || (gap_p_r < gap_s_r));
  assign time_ext  = WIDE_W'(pick_pred ? pred_time_r : succ_time_r);
  assign dist_ext  = WIDE_W'(pick_pred ? gap_p_r : gap_s_r);

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_ins || res_empty || res_found;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (res_found) begin
      status_r       <= STS_FOUND;
      found_handle_r <= pick_pred ? pred_handle_r : succ_handle_r;
      found_time_r   <= time_ext[KEY_FIELD_W-1:0];
      distance_r     <= dist_ext[KEY_FIELD_W-1:0];
    end else if (res_ins || res_empty) begin
      status_r       <= res_empty ? STS_EMPTY :
                        any_eq    ? STS_REPLACED :
                        full      ? STS_DROPPED : STS_INSERTED;
      found_handle_r <= '0;
      found_time_r   <= '0;
      distance_r     <= '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found_handle  = found_handle_r;
  assign out_found_time    = found_time_r;
  assign out_time_distance = distance_r;

endmodule

`default_nettype wire

// ===== src/tsnt_checker.sv =====
`default_nettype none

module tsnt_checker import tsnt_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   out_valid,
  input wire logic [STATUS_W-1:0]    out_status,
  input wire logic [HANDLE_W-1:0]    out_found_handle,
  input wire logic [KEY_FIELD_W-1:0] out_found_time,
  input wire logic [KEY_FIELD_W-1:0] out_time_distance
);

  // an accepted word keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // a result is given only once the work is finished
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // one result per word, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // only a found record carries non-zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STS_FOUND) |->
      (out_found_handle == '0 && out_found_time == '0 && out_time_distance == '0))
    else $error("non-zero fields on a result without a record");

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STS_INSERTED || out_status == STS_REPLACED ||
                   out_status == STS_DROPPED  || out_status == STS_FOUND ||
                   out_status == STS_EMPTY))
    else $error("undefined status code");

endmodule

bind time_sorted_nearest_table_core tsnt_checker u_tsnt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_found_handle  (out_found_handle),
  .out_found_time    (out_found_time),
  .out_time_distance (out_time_distance)
);

`default_nettype wire
